### hw/rtl/r2fft_pkg.sv
`default_nettype none
package r2fft_pkg;

    localparam int WORK_BITS = 25;

    // action field of an input transaction
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERM,
        ST_SWAP,
        ST_RD,
        ST_MUL,
        ST_ADD,
        ST_WR,
        ST_OUT
    } t_state;

    // result of one butterfly
    typedef struct packed {
        logic signed [WORK_BITS-1:0] ur;
        logic signed [WORK_BITS-1:0] ui;
        logic signed [WORK_BITS-1:0] vr;
        logic signed [WORK_BITS-1:0] vi;
    } t_bfly;

    function automatic logic signed [WORK_BITS-1:0] sat_work(input logic signed [WORK_BITS+1:0] x);
        logic signed [WORK_BITS+1:0] hi;
        logic signed [WORK_BITS+1:0] lo;
        hi = (WORK_BITS+2)'((64'sd1 <<< (WORK_BITS-1)) - 64'sd1);
        lo = -(WORK_BITS+2)'(64'sd1 <<< (WORK_BITS-1));
        if (x > hi) return hi[WORK_BITS-1:0];
        if (x < lo) return lo[WORK_BITS-1:0];
        return x[WORK_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/radix2_fft_engine.sv
`default_nettype none
// channel | dir | tdata fields (low bit up)                         | tuser
// s_axis  | in  | sample_real[15:0], sample_imag[31:16], bin[40:32] | action
// m_axis  | out | bin_real[24:0], bin_imag[49:25]                  | result_valid
// a load is accepted whenever the block is idle; the last load of a frame starts the
// transform: a bit-reversal scan over all points that swaps each reversed pair,
// then the butterflies, each through read, multiply, add and write states. a read
// passes through the OUT state, which fills the output register once it is free.
// synchronous active-low reset clears control only. s_axis_tready is low while not idle;
// a read waits for a free output.
module radix2_fft_engine #(
    parameter int POINTS       = 512,
    parameter int SAMPLE_BITS  = 16,
    parameter int TWIDDLE_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // sample_real, sample_imag, bin_select
    input  wire         s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // bin_real, bin_imag
    output logic        m_axis_tuser    // result_valid
);
    localparam int W = r2fft_pkg::WORK_BITS;
    localparam int LG = $clog2(POINTS);

    r2fft_pkg::t_state r_state, n_state;

    logic signed [W-1:0] r_mem_r [POINTS];
    logic signed [W-1:0] r_mem_i [POINTS];

    logic [LG:0]   r_cnt;        // load count
    logic          r_done;
    logic [LG-1:0] r_i;          // permutation index / butterfly index
    logic [LG-1:0] r_stage;      // log2 of half
    logic [LG-1:0] r_a, r_b;     // addresses
    logic signed [W-1:0] r_rd_ar, r_rd_ai, r_rd_br, r_rd_bi;
    logic [LG-1:0] r_bin;
    logic          r_out_v;
    logic [2*W:0]  r_out;

    logic [LG-1:0] s_rev;
    logic [LG-1:0] s_ua, s_va, s_low, s_hi;
    logic [LG-2:0] s_tw_idx;
    logic signed [TWIDDLE_BITS-1:0] s_wc, s_ws;
    r2fft_pkg::t_bfly s_res;
    logic s_in_acc;
    logic s_out_free;
    logic signed [SAMPLE_BITS-1:0] s_sr, s_si;

    assign s_in_acc = s_axis_tvalid && s_axis_tready;
    assign s_out_free = !r_out_v || m_axis_tready;
    assign s_sr = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_si = s_axis_tdata[16+SAMPLE_BITS-1:16];

    // bit reverse of the permutation index
    always_comb begin
        for (int b = 0; b < LG; b++) s_rev[b] = r_i[LG-1-b];
    end

    // butterfly addresses: insert a zero at bit position stage
    always_comb begin
        s_low = r_i & LG'((1 << r_stage) - 1);
        s_hi  = (r_i >> r_stage) << (r_stage + 1);
        s_ua  = s_hi | s_low;
        s_va  = s_ua | LG'(1 << r_stage);
        s_tw_idx = (LG-1)'(s_low << (LG - 1 - r_stage));
    end

    r2fft_twiddle #(.POINTS(POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_tw (
        .i_clk(i_clk), .i_idx(s_tw_idx), .o_cos(s_wc), .o_sin(s_ws)
    );

    r2fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
        .i_clk(i_clk),
        .i_mul_en(r_state == r2fft_pkg::ST_MUL),
        .i_add_en(r_state == r2fft_pkg::ST_ADD),
        .i_ur(r_rd_ar), .i_ui(r_rd_ai), .i_xr(r_rd_br), .i_xi(r_rd_bi),
        .i_wc(s_wc), .i_ws(s_ws), .o_res(s_res)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        s_axis_tready = (r_state == r2fft_pkg::ST_IDLE);
        case (r_state)
            r2fft_pkg::ST_IDLE: begin
                if (s_in_acc) begin
                    if (s_axis_tuser == r2fft_pkg::ACT_READ) n_state = r2fft_pkg::ST_OUT;
                    else if (r_cnt == (LG+1)'(POINTS - 1)) n_state = r2fft_pkg::ST_PERM;
                end
            end
            r2fft_pkg::ST_PERM: begin
                if (r_i < s_rev) n_state = r2fft_pkg::ST_SWAP;
                else if (r_i == LG'(POINTS - 1)) n_state = r2fft_pkg::ST_RD;
            end
            r2fft_pkg::ST_SWAP: n_state = r2fft_pkg::ST_PERM;
            r2fft_pkg::ST_RD:  n_state = r2fft_pkg::ST_MUL;
            r2fft_pkg::ST_MUL: n_state = r2fft_pkg::ST_ADD;
            r2fft_pkg::ST_ADD: n_state = r2fft_pkg::ST_WR;
            r2fft_pkg::ST_WR: begin
                if (r_i == LG'(POINTS/2 - 1) && r_stage == LG'(LG - 1))
                    n_state = r2fft_pkg::ST_IDLE;
                else n_state = r2fft_pkg::ST_RD;
            end
            r2fft_pkg::ST_OUT: begin
                if (s_out_free) n_state = r2fft_pkg::ST_IDLE;
            end
            default: n_state = r2fft_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r2fft_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_i     <= '0;
            r_stage <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            // output register fills when the read gets a free slot
            if (r_state == r2fft_pkg::ST_OUT && s_out_free) r_out_v <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
            case (r_state)
                r2fft_pkg::ST_IDLE: begin
                    if (s_in_acc && s_axis_tuser == r2fft_pkg::ACT_LOAD) begin
                        r_done <= 1'b0;
                        r_i    <= '0;
                        r_stage <= '0;
                        if (r_cnt == (LG+1)'(POINTS - 1)) r_cnt <= '0;
                        else r_cnt <= r_cnt + 1'b1;
                    end
                end
                r2fft_pkg::ST_PERM: begin
                    if (!(r_i < s_rev)) r_i <= r_i + 1'b1;
                end
                r2fft_pkg::ST_SWAP: r_i <= r_i + 1'b1;
                r2fft_pkg::ST_WR: begin
                    if (r_i == LG'(POINTS/2 - 1)) begin
                        r_i <= '0;
                        if (r_stage == LG'(LG - 1)) r_done <= 1'b1;
                        else r_stage <= r_stage + 1'b1;
                    end else r_i <= r_i + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // working store: registered reads, swap written in the cycle after its read
    always_ff @(posedge i_clk) begin
        case (r_state)
            r2fft_pkg::ST_IDLE: begin
                if (s_in_acc && s_axis_tuser == r2fft_pkg::ACT_LOAD) begin
                    r_mem_r[r_cnt[LG-1:0]] <= W'(s_sr);
                    r_mem_i[r_cnt[LG-1:0]] <= W'(s_si);
                end
                r_bin <= s_axis_tdata[32 +: LG];
            end
            r2fft_pkg::ST_PERM: begin
                r_a <= r_i;
                r_b <= s_rev;
                r_rd_ar <= r_mem_r[r_i];
                r_rd_ai <= r_mem_i[r_i];
                r_rd_br <= r_mem_r[s_rev];
                r_rd_bi <= r_mem_i[s_rev];
            end
            r2fft_pkg::ST_SWAP: begin
                r_mem_r[r_a] <= r_rd_br;
                r_mem_i[r_a] <= r_rd_bi;
                r_mem_r[r_b] <= r_rd_ar;
                r_mem_i[r_b] <= r_rd_ai;
            end
            r2fft_pkg::ST_RD: begin
                r_a <= s_ua;
                r_b <= s_va;
                r_rd_ar <= r_mem_r[s_ua];
                r_rd_ai <= r_mem_i[s_ua];
                r_rd_br <= r_mem_r[s_va];
                r_rd_bi <= r_mem_i[s_va];
            end
            r2fft_pkg::ST_WR: begin
                r_mem_r[r_a] <= s_res.ur;
                r_mem_i[r_a] <= s_res.ui;
                r_mem_r[r_b] <= s_res.vr;
                r_mem_i[r_b] <= s_res.vi;
            end
            r2fft_pkg::ST_OUT: begin
                if (s_out_free) begin
                    if (r_done) r_out <= {1'b1, r_mem_i[r_bin], r_mem_r[r_bin]};
                    else r_out <= '0;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {6'd0, r_out[2*W-1:0]};
    assign m_axis_tuser  = r_out[2*W];

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != r2fft_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == r2fft_pkg::ST_OUT) |=> m_axis_tvalid)
        else $error("read gave no result");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in_acc && s_axis_tuser == r2fft_pkg::ACT_LOAD) |=> !r_done)
        else $error("done not cleared on load");
`endif
endmodule
`default_nettype wire

### hw/rtl/r2fft_twiddle.sv
`default_nettype none
// quantized twiddle lookup, table built at elaboration from a Q30 Taylor series
module r2fft_twiddle #(
    parameter int POINTS       = 512,
    parameter int TWIDDLE_BITS = 16
) (
    input  wire                           i_clk,
    input  wire  [$clog2(POINTS)-2:0]     i_idx,
    output logic signed [TWIDDLE_BITS-1:0] o_cos,
    output logic signed [TWIDDLE_BITS-1:0] o_sin
);
    localparam int HALF = POINTS / 2;
    localparam int QUARTER = POINTS / 4;
    localparam longint PI_Q30 = 64'd3373259426;
    localparam longint ONE_Q30 = 64'd1073741824;

    typedef logic signed [TWIDDLE_BITS-1:0] t_tw_arr [HALF];

    function automatic logic signed [TWIDDLE_BITS-1:0] to_tw(input longint v);
        longint q;
        longint top;
        int sh;
        sh = 31 - TWIDDLE_BITS;
        top = (64'sd1 <<< (TWIDDLE_BITS - 1)) - 1;
        if (v < 0) v = 0;
        if (v > ONE_Q30) v = ONE_Q30;
        q = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (q > top) q = top;
        return TWIDDLE_BITS'(q);
    endfunction

    // shift-subtract long division, used only while building the table
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    function automatic t_tw_arr build(input bit want_cos);
        t_tw_arr tab;
        longint unsigned x;
        longint unsigned term;
        longint cs;
        longint sn;
        longint unsigned a;
        logic signed [TWIDDLE_BITS-1:0] qc;
        logic signed [TWIDDLE_BITS-1:0] qs;
        for (int k = 0; k < HALF; k++) begin
            a = (k < QUARTER) ? longint'(k) : longint'(k - QUARTER);
            x = ((2 * PI_Q30) * a + HALF) / POINTS;
            term = ONE_Q30;
            cs = ONE_Q30;
            sn = 0;
            for (int n = 1; n <= 24; n++) begin
                if (term != 0) begin
                    term = udiv((term * x) >> 30, longint'(n));
                    case (n % 4)
                        1: sn = sn + longint'(term);
                        2: cs = cs - longint'(term);
                        3: sn = sn - longint'(term);
                        default: cs = cs + longint'(term);
                    endcase
                end
            end
            qc = to_tw(cs);
            qs = to_tw(sn);
            if (k < QUARTER) tab[k] = want_cos ? qc : qs;
            else             tab[k] = want_cos ? -qs : qc;
        end
        return tab;
    endfunction

    localparam t_tw_arr CosTab = build(1'b1);
    localparam t_tw_arr SinTab = build(1'b0);

    // registered table read
    always_ff @(posedge i_clk) begin
        o_cos <= CosTab[i_idx];
        o_sin <= SinTab[i_idx];
    end
endmodule
`default_nettype wire

### hw/rtl/r2fft_bfly.sv
`default_nettype none
// shared butterfly unit: multiply stage registered, then add/subtract with saturation
module r2fft_bfly #(
    parameter int TWIDDLE_BITS = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_mul_en,
    input  wire                                       i_add_en,
    input  wire  signed [r2fft_pkg::WORK_BITS-1:0]    i_ur,
    input  wire  signed [r2fft_pkg::WORK_BITS-1:0]    i_ui,
    input  wire  signed [r2fft_pkg::WORK_BITS-1:0]    i_xr,
    input  wire  signed [r2fft_pkg::WORK_BITS-1:0]    i_xi,
    input  wire  signed [TWIDDLE_BITS-1:0]            i_wc,
    input  wire  signed [TWIDDLE_BITS-1:0]            i_ws,
    output r2fft_pkg::t_bfly                          o_res
);
    localparam int W = r2fft_pkg::WORK_BITS;
    localparam int PW = W + TWIDDLE_BITS;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [SW-1:0] s_vr, s_vi;
    logic signed [W+1:0]  s_vr_n, s_vi_n;

    // four products, registered
    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_p0 <= PW'(i_xr) * PW'(i_wc);
            r_p1 <= PW'(i_xi) * PW'(i_ws);
            r_p2 <= PW'(i_xi) * PW'(i_wc);
            r_p3 <= PW'(i_xr) * PW'(i_ws);
        end
    end

    // rounding, half up
    always_comb begin
        s_vr = SW'(r_p0) + SW'(r_p1) + (SW'(1) <<< (TWIDDLE_BITS - 2));
        s_vi = SW'(r_p2) - SW'(r_p3) + (SW'(1) <<< (TWIDDLE_BITS - 2));
        s_vr_n = (W+2)'(s_vr >>> (TWIDDLE_BITS - 1));
        s_vi_n = (W+2)'(s_vi >>> (TWIDDLE_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_add_en) begin
            o_res.ur <= r2fft_pkg::sat_work((W+2)'(i_ur) + s_vr_n);
            o_res.ui <= r2fft_pkg::sat_work((W+2)'(i_ui) + s_vi_n);
            o_res.vr <= r2fft_pkg::sat_work((W+2)'(i_ur) - s_vr_n);
            o_res.vi <= r2fft_pkg::sat_work((W+2)'(i_ui) - s_vi_n);
        end
    end
endmodule
`default_nettype wire

### test/tb_radix2_fft_engine.sv
`default_nettype none
module tb_radix2_fft_engine;

    localparam int NPTS    = 512;
    localparam int LOG_N   = 9;
    localparam int TW_BITS = 16;
    localparam int WORK_BITS = r2fft_pkg::WORK_BITS;
    localparam int WATCHDOG_LIMIT = 60000;

    typedef struct {
        logic [WORK_BITS-1:0] re;
        logic [WORK_BITS-1:0] im;
        logic                 valid;
    } t_bin;

    // fft model and queue of bins still owed by the block
    class fft_scoreboard;
        longint wr[NPTS];
        longint wi[NPTS];
        longint cos_tab[NPTS/2+1];
        longint sin_tab[NPTS/2+1];
        int     load_cnt;
        bit     frame_done;
        t_bin   pending_bins[$];
        int     errors;
        int     loads;
        int     reads;
        int     frames;

        function new();
            load_cnt = 0;
            frame_done = 0;
            errors = 0;
            build_twiddles();
        endfunction

        // quantize a q30 value to the twiddle format
        function longint to_tw(longint v);
            longint q;
            if (v < 0) v = 0;
            if (v > 64'sd1073741824) v = 64'sd1073741824;
            q = (v + (64'sd1 << (30 - TW_BITS))) >>> (31 - TW_BITS);
            if (q > (64'sd1 << (TW_BITS - 1)) - 1) q = (64'sd1 << (TW_BITS - 1)) - 1;
            return q;
        endfunction

        // first-quadrant taylor series, mirrored for the second quadrant
        function void build_twiddles();
            longint unsigned term, x;
            longint c, s;
            int a;
            for (int k = 0; k < NPTS/2; k++) begin
                a = (k < NPTS/4) ? k : k - NPTS/4;
                x = (64'd6746518852 * a + NPTS/2) / NPTS;
                term = 64'd1073741824;
                c = 64'sd1073741824;
                s = 0;
                for (int n = 1; n <= 24 && term != 0; n++) begin
                    term = ((term * x) >> 30) / n;
                    case (n % 4)
                        1: s += longint'(term);
                        2: c -= longint'(term);
                        3: s -= longint'(term);
                        default: c += longint'(term);
                    endcase
                end
                if (k < NPTS/4) begin
                    cos_tab[k] = to_tw(c);
                    sin_tab[k] = to_tw(s);
                end else begin
                    cos_tab[k] = -to_tw(s);
                    sin_tab[k] = to_tw(c);
                end
            end
        endfunction

        function longint clip_work(longint v);
            if (v > (64'sd1 << (WORK_BITS - 1)) - 1) return (64'sd1 << (WORK_BITS - 1)) - 1;
            if (v < -(64'sd1 << (WORK_BITS - 1))) return -(64'sd1 << (WORK_BITS - 1));
            return v;
        endfunction

        // bit-reversal then in-place butterflies
        function void transform();
            int j, t, u, v;
            longint tmp, vr, vi, ur, ui;
            for (int i = 0; i < NPTS; i++) begin
                j = 0;
                for (int b = 0; b < LOG_N; b++)
                    if (i[b]) j |= 1 << (LOG_N - 1 - b);
                if (i < j) begin
                    tmp = wr[i]; wr[i] = wr[j]; wr[j] = tmp;
                    tmp = wi[i]; wi[i] = wi[j]; wi[j] = tmp;
                end
            end
            for (int len = 2; len <= NPTS; len <<= 1) begin
                for (int base = 0; base < NPTS; base += len) begin
                    for (int k = 0; k < len/2; k++) begin
                        u = base + k;
                        v = u + len/2;
                        t = (k * (NPTS / len)) % (NPTS/2);
                        vr = (wr[v] * cos_tab[t] + wi[v] * sin_tab[t]
                              + (64'sd1 << (TW_BITS - 2))) >>> (TW_BITS - 1);
                        vi = (wi[v] * cos_tab[t] - wr[v] * sin_tab[t]
                              + (64'sd1 << (TW_BITS - 2))) >>> (TW_BITS - 1);
                        ur = wr[u];
                        ui = wi[u];
                        wr[u] = clip_work(ur + vr);
                        wi[u] = clip_work(ui + vi);
                        wr[v] = clip_work(ur - vr);
                        wi[v] = clip_work(ui - vi);
                    end
                end
            end
        endfunction

        function void note_input(logic act, logic signed [15:0] re,
                                 logic signed [15:0] im, logic [8:0] sel);
            t_bin e;
            if (act == r2fft_pkg::ACT_LOAD) begin
                loads++;
                // first load of a frame drops the old transform
                if (load_cnt == 0) frame_done = 0;
                wr[load_cnt] = re;
                wi[load_cnt] = im;
                load_cnt++;
                if (load_cnt == NPTS) begin
                    transform();
                    load_cnt = 0;
                    frame_done = 1;
                    frames++;
                end
            end else begin
                reads++;
                if (frame_done) begin
                    e.re = wr[sel][WORK_BITS-1:0];
                    e.im = wi[sel][WORK_BITS-1:0];
                    e.valid = 1'b1;
                end else begin
                    e.re = '0;
                    e.im = '0;
                    e.valid = 1'b0;
                end
                pending_bins.push_back(e);
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [55:0] data, logic flag);
            t_bin e;
            if (pending_bins.size() == 0) begin
                report("bin transaction with nothing outstanding");
                return;
            end
            e = pending_bins.pop_front();
            if (data[24:0] !== e.re)
                report($sformatf("bin_real got %h want %h", data[24:0], e.re));
            if (data[49:25] !== e.im)
                report($sformatf("bin_imag got %h want %h", data[49:25], e.im));
            if (flag !== e.valid)
                report($sformatf("result_valid got %b want %b", flag, e.valid));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // sample_real, sample_imag, bin_select
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // bin_real, bin_imag
    logic        m_axis_tuser;   // result_valid

    fft_scoreboard sb;
    bit idle_on;
    int quiet_cycles;

    radix2_fft_engine u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sink side back-pressure
    always @(posedge i_clk)
        m_axis_tready <= (idle_on && $urandom_range(99) < 16) ? 1'b0 : 1'b1;

    // monitor both sides and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                              s_axis_tdata[40:32]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d bins outstanding",
                         sb.pending_bins.size());
                $display("tb_radix2_fft_engine failed");
                $finish;
            end
        end
    end

    // one transaction on the sample side
    task send(logic act, logic [15:0] re, logic [15:0] im, logic [8:0] sel);
        if (idle_on && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, sel, im, re};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task load(logic [15:0] re, logic [15:0] im);
        send(r2fft_pkg::ACT_LOAD, re, im, 9'($urandom));
    endtask

    task read_bin(logic [8:0] sel);
        send(r2fft_pkg::ACT_READ, 16'($urandom), 16'($urandom), sel);
    endtask

    function logic [15:0] rand_sample(bit full);
        if (full) return 16'($urandom);
        return 16'($urandom_range(0, 4095)) - 16'd2048;
    endfunction

    initial begin
        sb = new();
        idle_on = 1'b1;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = r2fft_pkg::ACT_LOAD;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reads with no finished transform
        read_bin(9'd0);
        read_bin(9'd511);

        // one frame: alternating extremes drive the adders into clipping,
        // random samples of mixed size fill the second half
        for (int k = 0; k < NPTS; k++) begin
            // no idling on either side for a stretch of the frame
            idle_on = !(k >= 64 && k < 192);
            if ($urandom_range(99) < 3) read_bin(9'($urandom));
            if (k < NPTS/2)
                load(k[0] ? 16'h8000 : 16'h7fff, k[1] ? 16'h7fff : 16'h8000);
            else
                load(rand_sample(k[2]), rand_sample(k[3]));
        end
        idle_on = 1'b1;
        read_bin(9'd0);
        read_bin(9'd1);
        read_bin(9'd256);
        read_bin(9'd511);
        read_bin(9'h155);
        read_bin(9'h0aa);

        // hold off until every bin has come back
        s_axis_tvalid <= 1'b0;
        while (sb.pending_bins.size() != 0) @(posedge i_clk);

        // a new frame discards the held transform
        load(16'h7fff, 16'h8000);
        read_bin(9'd0);
        for (int k = 1; k < 24; k++) begin
            load(rand_sample(1'b1), rand_sample(1'b0));
            if (k % 4 == 0) read_bin(9'($urandom));
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_bins.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d loads over %0d frames and %0d bin reads", sb.loads,
                 sb.frames, sb.reads);
        $display("clipping and random frame, reads before, between and after a transform");
        if (sb.errors == 0 && sb.pending_bins.size() == 0)
            $display("tb_radix2_fft_engine passed");
        else
            $display("tb_radix2_fft_engine failed");
        $finish;
    end

endmodule
`default_nettype wire
